@@ rtl/rfc8_pkg.sv @@
// shared types, constants and crc function for the range frame checker
package rfc8_pkg;

    localparam logic [7:0] HEADER_RESET = 8'h54;
    localparam logic [7:0] CRC_POLY     = 8'h07;

    // byte positions within a frame
    localparam logic [1:0] POS_HEADER = 2'd0;
    localparam logic [1:0] POS_DIST_HI = 2'd1;
    localparam logic [1:0] POS_DIST_LO = 2'd2;
    localparam logic [1:0] POS_CRC    = 2'd3;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_HDR_ERR = 2'd1,
        ST_CRC_ERR = 2'd2
    } t_frame_status;

    typedef struct packed {
        t_frame_status frame_status;
        logic [15:0]   distance;
    } t_frame_result;

    // msb-first crc-8 update over one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/rfc8_byte_if.sv @@
// byte request channel
interface rfc8_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

@@ rtl/rfc8_result_if.sv @@
// frame result channel
interface rfc8_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_status;
    logic [15:0] distance;

    modport source (output valid, output frame_status, output distance, input ready);
    modport sink (input valid, input frame_status, input distance, output ready);
endinterface

@@ rtl/rfc8_cfg_if.sv @@
// header register write channel
interface rfc8_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] header_value;

    modport source (output valid, output header_value, input ready);
    modport sink (input valid, input header_value, output ready);
endinterface

@@ rtl/rfc8_frame_core.sv @@
// frame position tracking, running crc and status decision
module rfc8_frame_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [7:0]             i_byte,
    input  logic [7:0]             i_header,
    output logic                   o_last,
    output rfc8_pkg::t_frame_result o_result
);

    logic [1:0] r_pos;
    logic [1:0] n_pos;
    logic [7:0] r_crc;
    logic [7:0] n_crc;
    logic [7:0] r_dist_hi;
    logic [7:0] r_dist_lo;
    logic       r_hdr_ok;

    assign o_last = (r_pos == rfc8_pkg::POS_CRC);
    assign n_pos  = r_pos + 2'd1;

    // header byte restarts the crc from zero
    assign n_crc = rfc8_pkg::crc8_update(
        (r_pos == rfc8_pkg::POS_HEADER) ? 8'h00 : r_crc, i_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= rfc8_pkg::POS_HEADER;
        end else if (i_step) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            case (r_pos)
                rfc8_pkg::POS_HEADER: begin
                    r_hdr_ok <= (i_byte == i_header);
                    r_crc    <= n_crc;
                end
                rfc8_pkg::POS_DIST_HI: begin
                    r_dist_hi <= i_byte;
                    r_crc     <= n_crc;
                end
                rfc8_pkg::POS_DIST_LO: begin
                    r_dist_lo <= i_byte;
                    r_crc     <= n_crc;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (!r_hdr_ok) begin
            o_result.frame_status = rfc8_pkg::ST_HDR_ERR;
        end else if (r_crc != i_byte) begin
            o_result.frame_status = rfc8_pkg::ST_CRC_ERR;
        end else begin
            o_result.frame_status = rfc8_pkg::ST_OK;
        end
        o_result.distance = {r_dist_hi, r_dist_lo};
    end

endmodule

@@ rtl/range_frame_checker_crc8_top.sv @@
// top level of the crc-8 checked range frame checker
// Takes one received byte per cycle and groups bytes into fixed four-byte frames
// (header, distance high, distance low, crc-8 with polynomial 0x07, initial 0).
// After the fourth byte of each frame one result comes out with a status
// (0 good, 1 header mismatch, 2 crc failure) and the big-endian distance; other
// bytes give no result. A byte is held in the input register while a
// combinational crc update and compare feeds the result register, so a result
// is registered from the frame's last byte. Sustained rate is one byte per
// clock; the input stalls only while a finished result waits in the output register
// and the next frame end is already pending. The header register resets to 0x54 and
// is compared with each frame's first byte when that byte is processed. Frame
// alignment is fixed from reset.
module range_frame_checker_crc8_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rfc8_byte_if.sink   i_rx,
    rfc8_cfg_if.sink    i_cfg,
    rfc8_result_if.source o_res
);

    logic                    r_in_valid;
    logic [7:0]              r_in_byte;
    logic [7:0]              r_header;
    logic                    r_out_valid;
    rfc8_pkg::t_frame_result r_out;
    logic                    core_last;
    rfc8_pkg::t_frame_result core_result;
    logic                    out_free;
    logic                    advance;

    assign out_free   = !r_out_valid || o_res.ready;
    assign advance    = r_in_valid && (!core_last || out_free);
    assign i_rx.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= rfc8_pkg::HEADER_RESET;
        end else if (i_cfg.valid) begin
            r_header <= i_cfg.header_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    rfc8_frame_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .i_header (r_header),
        .o_last   (core_last),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && core_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && core_last) begin
            r_out <= core_result;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.frame_status = r_out.frame_status;
    assign o_res.distance     = r_out.distance;

endmodule

@@ sim/tb_range_frame_checker_crc8_top.sv @@
// self-checking testbench for the crc-8 range frame checker with random traffic
`timescale 1ns / 100ps

module tb_range_frame_checker_crc8_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SHOWN_FAILS = 10;

    logic clk;
    logic rst_n;

    rfc8_byte_if   rx_if ();
    rfc8_cfg_if    cfg_if ();
    rfc8_result_if res_if ();

    range_frame_checker_crc8_top uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // deframer copy: header register and per-frame state
    logic [7:0]    hdr_cfg;
    logic [1:0]    frame_pos;
    logic [7:0]    crc_acc;
    logic [7:0]    dist_hi;
    logic [7:0]    dist_lo;
    logic          hdr_hit;

    logic [7:0]              tx_bytes[$];
    rfc8_pkg::t_frame_result pending_frames[$];
    rfc8_pkg::t_frame_result want;

    int n_pushed;
    int n_accepted;
    int n_frames;
    int n_good;
    int n_hdr_bad;
    int n_crc_bad;
    int n_hdr_writes;
    int n_fail;
    int cycles;
    int tx_gap;
    int tx_burst;
    int rx_stall;
    int rx_burst;

    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // msb-first, one message bit at a time
    function automatic logic [7:0] crc8_next(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = c;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ b[i];
            r  = {r[6:0], 1'b0};
            if (fb) begin
                r = r ^ rfc8_pkg::CRC_POLY;
            end
        end
        return r;
    endfunction

    // draw the wait before the next item, with occasional stretches of back-to-back traffic
    function automatic int draw_wait(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst = $urandom_range(15, 40);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic track_frame_byte(input logic [7:0] b);
        rfc8_pkg::t_frame_result fr;
        case (frame_pos)
            rfc8_pkg::POS_HEADER: begin
                hdr_hit   = (b == hdr_cfg);
                crc_acc   = crc8_next(8'h00, b);
                frame_pos = rfc8_pkg::POS_DIST_HI;
            end
            rfc8_pkg::POS_DIST_HI: begin
                dist_hi   = b;
                crc_acc   = crc8_next(crc_acc, b);
                frame_pos = rfc8_pkg::POS_DIST_LO;
            end
            rfc8_pkg::POS_DIST_LO: begin
                dist_lo   = b;
                crc_acc   = crc8_next(crc_acc, b);
                frame_pos = rfc8_pkg::POS_CRC;
            end
            default: begin
                if (!hdr_hit) begin
                    fr.frame_status = rfc8_pkg::ST_HDR_ERR;
                end else if (crc_acc != b) begin
                    fr.frame_status = rfc8_pkg::ST_CRC_ERR;
                end else begin
                    fr.frame_status = rfc8_pkg::ST_OK;
                end
                fr.distance = {dist_hi, dist_lo};
                pending_frames.push_back(fr);
                frame_pos = rfc8_pkg::POS_HEADER;
                crc_acc   = 8'h00;
            end
        endcase
    endtask

    task automatic note_failure(input string msg);
        n_fail++;
        if (n_fail <= SHOWN_FAILS) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    // byte driver
    always @(posedge clk) begin
        if (!rst_n) begin
            rx_if.valid   <= 1'b0;
            rx_if.rx_byte <= 8'h00;
        end else begin
            if (rx_if.valid && rx_if.ready) begin
                track_frame_byte(rx_if.rx_byte);
                n_accepted++;
            end
            if (rx_if.valid && !rx_if.ready) begin
                // hold the request until taken
            end else if (tx_gap > 0) begin
                tx_gap--;
                rx_if.valid <= 1'b0;
            end else if (tx_bytes.size() != 0) begin
                rx_if.valid   <= 1'b1;
                rx_if.rx_byte <= tx_bytes.pop_front();
                tx_gap = draw_wait(tx_burst);
            end else begin
                rx_if.valid <= 1'b0;
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk) begin
        if (!rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (pending_frames.size() == 0) begin
                    note_failure($sformatf("unexpected result status=%0d distance=%h",
                                           res_if.frame_status, res_if.distance));
                end else begin
                    want = pending_frames.pop_front();
                    n_frames++;
                    case (want.frame_status)
                        rfc8_pkg::ST_OK:      n_good++;
                        rfc8_pkg::ST_HDR_ERR: n_hdr_bad++;
                        default:              n_crc_bad++;
                    endcase
                    if (res_if.frame_status !== want.frame_status ||
                        res_if.distance !== want.distance) begin
                        note_failure($sformatf(
                            "frame %0d: expected status=%0d distance=%h, %s=%0d distance=%h",
                            n_frames, want.frame_status, want.distance, "got status",
                            res_if.frame_status, res_if.distance));
                    end
                end
                rx_stall = draw_wait(rx_burst);
                res_if.ready <= (rx_stall == 0);
            end else if (rx_stall > 0) begin
                rx_stall--;
                res_if.ready <= (rx_stall == 0);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[range_frame_checker_crc8_top] ERROR");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
        n_pushed++;
    endtask

    // realigns to a frame boundary first, crc_flip corrupts the check byte
    task automatic push_frame(input logic [7:0] hdr, input logic [7:0] hi,
                              input logic [7:0] lo, input logic [7:0] crc_flip);
        while (n_pushed % 4 != 0) begin
            push_byte(8'($urandom_range(0, 255)));
        end
        push_byte(hdr);
        push_byte(hi);
        push_byte(lo);
        push_byte(crc8_next(crc8_next(crc8_next(8'h00, hdr), hi), lo) ^ crc_flip);
    endtask

    // waits until every byte is taken and every frame result has come back
    task automatic settle_link();
        do begin
            @(posedge clk);
        end while (n_accepted != n_pushed || pending_frames.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_header(input logic [7:0] v);
        @(posedge clk);
        cfg_if.valid        <= 1'b1;
        cfg_if.header_value <= v;
        do begin
            @(posedge clk);
        end while (!cfg_if.ready);
        hdr_cfg = v;
        n_hdr_writes++;
        cfg_if.valid <= 1'b0;
    endtask

    task automatic run_traffic(input int n_bytes);
        int stop_at;
        int k;
        stop_at = n_pushed + n_bytes;
        while (n_pushed < stop_at) begin
            k = $urandom_range(0, 9);
            if (k <= 5) begin
                push_frame(hdr_cfg, pick_byte(), pick_byte(), 8'h00);
            end else if (k == 6) begin
                push_frame(hdr_cfg ^ 8'($urandom_range(1, 255)), pick_byte(), pick_byte(),
                           8'h00);
            end else if (k == 7) begin
                push_frame(hdr_cfg, pick_byte(), pick_byte(), 8'($urandom_range(1, 255)));
            end else if (k == 8) begin
                repeat (4) push_byte(8'($urandom_range(0, 255)));
            end else begin
                // stray bytes knock the stream out of frame until the next realign
                repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        rst_n               = 1'b0;
        rx_if.valid         = 1'b0;
        rx_if.rx_byte       = 8'h00;
        cfg_if.valid        = 1'b0;
        cfg_if.header_value = 8'h00;
        res_if.ready        = 1'b0;
        hdr_cfg   = rfc8_pkg::HEADER_RESET;
        frame_pos = rfc8_pkg::POS_HEADER;
        crc_acc   = 8'h00;
        dist_hi   = 8'h00;
        dist_lo   = 8'h00;
        hdr_hit   = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed frames under the reset header
        push_frame(8'h54, 8'h00, 8'h00, 8'h00);
        push_frame(8'h54, 8'hFF, 8'hFF, 8'h00);
        push_frame(8'hFF, 8'h00, 8'hFF, 8'h00);
        push_frame(8'h54, 8'hFF, 8'h00, 8'hFF);
        push_frame(8'h00, 8'hA5, 8'h5A, 8'h01);
        // header changed after the first byte of a frame was compared
        push_byte(8'h54);
        push_byte(8'h01);
        settle_link();
        write_header(8'h00);
        push_byte(8'h02);
        push_byte(crc8_next(crc8_next(crc8_next(8'h00, 8'h54), 8'h01), 8'h02));
        push_frame(8'h00, 8'h80, 8'h01, 8'h00);

        run_traffic(160);
        settle_link();
        write_header(8'hFF);
        run_traffic(160);
        settle_link();
        write_header(8'($urandom_range(1, 254)));
        run_traffic(160);
        settle_link();
        write_header(rfc8_pkg::HEADER_RESET);
        run_traffic(160);
        settle_link();
        repeat (10) @(posedge clk);

        $display("sent %0d bytes in %0d cycles, %0d header writes incl. 0x00 and 0xff",
                 n_accepted, cycles, n_hdr_writes);
        $display("checked %0d frames: %0d good, %0d header mismatch, %0d crc failed",
                 n_frames, n_good, n_hdr_bad, n_crc_bad);
        $display("%0d failures", n_fail);
        if (n_fail == 0 && pending_frames.size() == 0) begin
            $display("[range_frame_checker_crc8_top] OK");
        end else begin
            $display("[range_frame_checker_crc8_top] ERROR");
        end
        $finish;
    end

endmodule
